// ----- rtl/msu_pkg.sv -----
// ----------------------------------------------------------------------------
// msu_pkg
// Shared types and constants of the matrix stack unit.
// ----------------------------------------------------------------------------
package msu_pkg;

   typedef enum logic [2:0] {
      KIND_MODE     = 3'd0,
      KIND_OPERAND  = 3'd1,
      KIND_LOAD     = 3'd2,
      KIND_MULTIPLY = 3'd3,
      KIND_IDENTITY = 3'd4,
      KIND_PUSH     = 3'd5,
      KIND_POP      = 3'd6,
      KIND_READ     = 3'd7
   } kind_type;

   localparam logic [1:0] MODE_TEXTURE    = 2'd0;
   localparam logic [1:0] MODE_MODELVIEW  = 2'd1;
   localparam logic [1:0] MODE_PROJECTION = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_PUSH_FULL = 2'd1;
   localparam logic [1:0] STATUS_POP_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_IDENT,
      ST_MUL_RD,
      ST_MUL_RUN,
      ST_MUL_WR,
      ST_PUSH,
      ST_READ,
      ST_READ_WAIT,
      ST_RESPOND
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       clear_wr;
      logic       load_wr;
      logic       ident_wr;
      logic       mul_load;
      logic       mul_step;
      logic       mul_wr;
      logic       push_rd;
      logic       push_wr;
      logic       top_rd;
      logic       capture;
      logic       level_up;
      logic       level_down;
      logic       mode_wr;
      logic       operand_wr;
      logic [3:0] elem;
      logic [1:0] kk;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
   } stat_type;

   function automatic logic [31:0] identity_elem(input logic [3:0] e);
      return (e[3:2] == e[1:0]) ? 32'd1 : 32'd0;
   endfunction

endpackage

// ----- rtl/msu_datapath.sv -----
// ----------------------------------------------------------------------------
// msu_datapath
// Stack memory, levels, mode, operand buffer and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
module msu_datapath #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  msu_pkg::cmd_type    cmd,
   input  logic [1:0]          mode_sel,
   input  logic [3:0]          in_index,
   input  logic [31:0]         in_value,
   output msu_pkg::stat_type   stat,
   output logic [31:0]         rd_value,
   output logic [4:0]          level_out
);

   localparam int LW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int AW = LW + 6;
   localparam int MEM_DEPTH = 3 * 16 * (1 << LW);

   logic [31:0] mem [MEM_DEPTH];
   logic [LW-1:0] level_ff [3];
   logic [1:0]    mode_ff;
   logic [31:0]   operand_ff [16];
   logic [31:0]   rdata_ff;
   logic [31:0]   acc_ff;
   logic [31:0]   prod_ff [16];
   logic [31:0]   top_ff [4];
   logic [AW-1:0] clr_ff;

   logic [1:0]    stk;
   logic [LW-1:0] cur_level;
   logic [LW-1:0] addr_level;
   logic [AW-1:0] addr;
   logic [31:0]   wdata;
   logic          we;

   // map mode to stack index; code 3 never stored
   assign stk       = (mode_ff == msu_pkg::MODE_TEXTURE)    ? 2'd0 :
                      (mode_ff == msu_pkg::MODE_PROJECTION) ? 2'd2 : 2'd1;
   assign cur_level = level_ff[stk];

   // push writes one level up, everything else at the top; clear sweeps all
   assign addr_level = cmd.push_wr ? cur_level + 1'b1 : cur_level;
   assign addr = cmd.clear_wr ? clr_ff : {stk, addr_level, cmd.elem};

   // advance the clear pointer over the whole memory
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_comb begin
      we    = 1'b0;
      wdata = '0;
      if (cmd.clear_wr) begin
         we = 1'b1;
      end else if (cmd.load_wr) begin
         we = 1'b1; wdata = operand_ff[cmd.elem];
      end else if (cmd.ident_wr) begin
         we = 1'b1; wdata = msu_pkg::identity_elem(cmd.elem);
      end else if (cmd.mul_wr) begin
         we = 1'b1; wdata = prod_ff[cmd.elem];
      end else if (cmd.push_wr) begin
         we = 1'b1; wdata = rdata_ff;
      end
   end

   // stack memory: one port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   // hold levels and mode
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff[0] <= '0;
         level_ff[1] <= '0;
         level_ff[2] <= '0;
         mode_ff     <= msu_pkg::MODE_MODELVIEW;
      end else begin
         if (cmd.mode_wr && mode_sel != 2'd3) begin
            mode_ff <= mode_sel;
         end
         if (cmd.level_up) begin
            level_ff[stk] <= cur_level + 1'b1;
         end else if (cmd.level_down) begin
            level_ff[stk] <= cur_level - 1'b1;
         end
      end
   end

   // operand buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) operand_ff[i] <= '0;
      end else if (cmd.operand_wr) begin
         operand_ff[in_index] <= in_value;
      end
   end

   // gather one row of the top matrix, then one product term per step, summed per output element
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         top_ff[cmd.kk] <= rdata_ff;
      end
      if (cmd.mul_step) begin
         acc_ff <= (cmd.kk == 2'd0 ? 32'd0 : acc_ff)
                   + top_ff[cmd.kk] * operand_ff[{cmd.elem[3:2], cmd.kk}];
         if (cmd.kk == 2'd3) begin
            prod_ff[cmd.elem] <= (acc_ff
                   + top_ff[cmd.kk] * operand_ff[{cmd.elem[3:2], cmd.kk}]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_value <= rdata_ff;
      end
   end

   assign stat.full  = ({1'b0, cur_level} + 1'b1) >= (LW+1)'(STACK_DEPTH);
   assign stat.empty = (cur_level == '0);
   assign level_out  = 5'(cur_level);

endmodule

// ----- rtl/msu_controller.sv -----
// ----------------------------------------------------------------------------
// msu_controller
// Command sequencer: clears the memory after reset, walks elements per command.
// ----------------------------------------------------------------------------
module msu_controller #(
   parameter int STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               is_read,
   output logic [1:0]         status,
   input  msu_pkg::stat_type  stat,
   output msu_pkg::cmd_type   cmd
);

   localparam int LW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = LW + 6;
   localparam int CLEAR_LAST = 3 * 16 * (1 << LW) - 1;

   msu_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [3:0]    row_ff, row_in;
   logic [1:0]    kk_ff, kk_in;
   logic          read_ff, read_in;
   logic [1:0]    status_ff, status_in;
   logic          accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != msu_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == msu_pkg::ST_RESPOND);
   assign is_read   = read_ff;
   assign status    = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= msu_pkg::ST_CLEAR;
         cnt_ff    <= '0;
         row_ff    <= '0;
         kk_ff     <= '0;
         read_ff   <= 1'b0;
         status_ff <= msu_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         row_ff    <= row_in;
         kk_ff     <= kk_in;
         read_ff   <= read_in;
         status_ff <= status_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      row_in    = row_ff;
      kk_in     = kk_ff;
      read_in   = read_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.elem  = cnt_ff[3:0];
      cmd.kk    = kk_ff;
      case (state_ff)
         msu_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CLEAR_LAST)) begin
               state_in = msu_pkg::ST_IDLE;
               cnt_in   = '0;
            end
         end
         msu_pkg::ST_IDLE: begin
            cnt_in = '0;
            kk_in  = '0;
            row_in = '0;
            if (accept) begin
               read_in   = 1'b0;
               status_in = msu_pkg::STATUS_OK;
               state_in  = msu_pkg::ST_RESPOND;
               case (msu_pkg::kind_type'(req_kind))
                  msu_pkg::KIND_MODE:     cmd.mode_wr = 1'b1;
                  msu_pkg::KIND_OPERAND:  cmd.operand_wr = 1'b1;
                  msu_pkg::KIND_LOAD:     state_in = msu_pkg::ST_LOAD;
                  msu_pkg::KIND_MULTIPLY: state_in = msu_pkg::ST_MUL_RD;
                  msu_pkg::KIND_IDENTITY: state_in = msu_pkg::ST_IDENT;
                  msu_pkg::KIND_PUSH: begin
                     if (stat.full) status_in = msu_pkg::STATUS_PUSH_FULL;
                     else state_in = msu_pkg::ST_PUSH;
                  end
                  msu_pkg::KIND_POP: begin
                     if (stat.empty) status_in = msu_pkg::STATUS_POP_EMPTY;
                     else cmd.level_down = 1'b1;
                  end
                  msu_pkg::KIND_READ: begin
                     read_in  = 1'b1;
                     state_in = msu_pkg::ST_READ;
                  end
                  default: state_in = msu_pkg::ST_RESPOND;
               endcase
            end
         end
         msu_pkg::ST_LOAD, msu_pkg::ST_IDENT: begin
            cmd.load_wr  = (state_ff == msu_pkg::ST_LOAD);
            cmd.ident_wr = (state_ff == msu_pkg::ST_IDENT);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[3:0] == 4'd15) state_in = msu_pkg::ST_RESPOND;
         end
         msu_pkg::ST_PUSH: begin
            // read element at top, then write it one level up from the registered read
            cmd.elem    = cnt_ff[4] ? row_ff : cnt_ff[3:0];
            cmd.push_wr = cnt_ff[4];
            if (cnt_ff[4]) begin
               cnt_in = {cnt_ff[CW-1:5], 1'b0, row_ff + 1'b1};
               if (row_ff == 4'd15) begin
                  cmd.level_up = 1'b1;
                  state_in     = msu_pkg::ST_RESPOND;
               end
            end else begin
               row_in = cnt_ff[3:0];
               cnt_in = {cnt_ff[CW-1:5], 1'b1, cnt_ff[3:0]};
            end
         end
         msu_pkg::ST_MUL_RD: begin
            // read row r of top: elements r, r+4, r+8, r+12, plus a final step for the last word;
            // each word lands in its column slot from the registered read, in the cycle after its read
            cmd.elem     = {cnt_ff[1:0], row_ff[1:0]};
            cmd.mul_load = (cnt_ff[2:0] != 3'd0);
            cmd.kk       = 2'(cnt_ff[1:0] - 2'd1);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == 3'd4) begin
               cnt_in   = '0;
               kk_in    = '0;
               state_in = msu_pkg::ST_MUL_RUN;
            end
         end
         msu_pkg::ST_MUL_RUN: begin
            // column c = cnt[1:0], row from row_ff
            cmd.mul_step = 1'b1;
            cmd.elem     = {cnt_ff[1:0], row_ff[1:0]};
            kk_in        = kk_ff + 1'b1;
            if (kk_ff == 2'd3) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff[1:0] == 2'd3) begin
                  cnt_in = '0;
                  row_in = row_ff + 1'b1;
                  state_in = (row_ff[1:0] == 2'd3) ? msu_pkg::ST_MUL_WR
                                                  : msu_pkg::ST_MUL_RD;
               end
            end
         end
         msu_pkg::ST_MUL_WR: begin
            cmd.mul_wr = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[3:0] == 4'd15) begin
               row_in   = '0;
               state_in = msu_pkg::ST_RESPOND;
            end
         end
         msu_pkg::ST_READ: begin
            cmd.elem = row_ff;
            state_in = msu_pkg::ST_READ_WAIT;
         end
         msu_pkg::ST_READ_WAIT: begin
            cmd.capture = 1'b1;
            state_in    = msu_pkg::ST_RESPOND;
         end
         msu_pkg::ST_RESPOND: begin
            if (!rsp_stall) state_in = msu_pkg::ST_IDLE;
         end
         default: state_in = msu_pkg::ST_IDLE;
      endcase
   end

   // responses only come out of the response state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == msu_pkg::ST_RESPOND)
      else $error("response outside respond state");
   assert property (@(posedge clock) disable iff (reset)
      cmd.push_wr |-> !stat.full)
      else $error("push write at full stack");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.load_wr, cmd.ident_wr, cmd.mul_wr, cmd.push_wr}))
      else $error("conflicting memory writes");

endmodule

// ----- rtl/matrix_stack_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_stack_unit
// Three stacks of 4x4 integer matrices with load, identity, multiply, push, pop, read.
// ----------------------------------------------------------------------------
// One word in, one word out per command; commands run one at a time. Every
// accepted command ends in the response state. A multiply alternates a
// read of one row of the top matrix with that row's multiply-accumulate
// steps, for all four rows, then writes the product back; the single-port
// stack memory serialises all of this work.
// After reset the memory, 3*16*2^ceil(log2(STACK_DEPTH)) words (1536 at the
// default), is cleared before the first word is taken.
module matrix_stack_unit #(
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_mode_select,
   input  logic [3:0]  req_element_index,
   input  logic [31:0] req_element_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_value,
   output logic [4:0]  rsp_stack_level,
   output logic [1:0]  rsp_status
);

   msu_pkg::cmd_type  cmd;
   msu_pkg::stat_type stat;
   logic [31:0] rd_value;
   logic        is_read;
   logic [3:0]  index_ff;

   // hold index for read while busy
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) index_ff <= req_element_index;
   end

   msu_controller #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind,
      .rsp_valid, .rsp_stall, .is_read, .status(rsp_status), .stat, .cmd
   );

   msu_pkg::cmd_type dp_cmd;
   always_comb begin
      dp_cmd = cmd;
      if (cmd == '0 || (!cmd.clear_wr && !cmd.load_wr && !cmd.ident_wr &&
          !cmd.mul_wr && !cmd.push_wr && !cmd.mul_load && !cmd.mul_step &&
          !cmd.capture && !req_stall)) begin
         dp_cmd.elem = cmd.elem;
      end
      if (!req_stall) dp_cmd.elem = req_element_index;
      else if (!cmd.clear_wr && !cmd.load_wr && !cmd.ident_wr && !cmd.mul_wr &&
               !cmd.push_wr && !cmd.mul_load && !cmd.mul_step && !cmd.capture &&
               !rsp_valid && is_read) dp_cmd.elem = index_ff;
   end

   msu_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .cmd(dp_cmd), .mode_sel(req_mode_select),
      .in_index(req_element_index), .in_value(req_element_value),
      .stat, .rd_value, .level_out(rsp_stack_level)
   );

   assign rsp_read_value = is_read ? rd_value : 32'd0;

endmodule

// ----- tb/sv/matrix_stack_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_stack_unit_test
// Self-checking bench for the three-stack 4x4 integer matrix unit.
// ----------------------------------------------------------------------------
// A local model of the stacks predicts every response word. Directed tests
// cover mode select, operand extremes, load, multiply, identity, push at a
// full stack, pop at the bottom and stale levels; random phases follow, with
// sender gaps and receiver stalls varied from phase to phase.
module matrix_stack_unit_test;

   localparam int DEPTH    = 32;
   localparam int WATCHDOG = 6000;

   typedef struct packed {
      logic [31:0] read_value;
      logic [4:0]  stack_level;
      logic [1:0]  status;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = 3'd0;
   logic [1:0]  req_mode_select = 2'd0;
   logic [3:0]  req_element_index = 4'd0;
   logic [31:0] req_element_value = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_value;
   logic [4:0]  rsp_stack_level;
   logic [1:0]  rsp_status;

   // model state
   logic [31:0] model_stack [3][DEPTH][16];
   logic [4:0]  model_level [3];
   logic [1:0]  model_mode;
   logic [31:0] model_operand [16];

   reply_type   pending_replies [$];
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          failures = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          quiet_cycles = 0;
   int          refusals = 0;

   matrix_stack_unit #(.STACK_DEPTH(DEPTH)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_mode_select   (req_mode_select),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_value    (rsp_read_value),
      .rsp_stack_level   (rsp_stack_level),
      .rsp_status        (rsp_status)
   );

   always #10 clock = ~clock;

   // clear the model to its reset contents
   task automatic model_clear();
      for (int m = 0; m < 3; m++) begin
         model_level[m] = '0;
         for (int l = 0; l < DEPTH; l++)
            for (int e = 0; e < 16; e++) model_stack[m][l][e] = '0;
      end
      for (int e = 0; e < 16; e++) model_operand[e] = '0;
      model_mode = msu_pkg::MODE_MODELVIEW;
   endtask

   // apply one command word to the model and return the predicted reply
   function automatic reply_type apply_command(logic [2:0] kind, logic [1:0] sel,
                                               logic [3:0] idx, logic [31:0] val);
      reply_type   r;
      logic [31:0] prod [16];
      logic [31:0] acc;
      int          m;
      int          lv;
      r = '0;
      m = model_mode;
      lv = model_level[m];
      case (msu_pkg::kind_type'(kind))
         msu_pkg::KIND_MODE: begin
            if (sel <= msu_pkg::MODE_PROJECTION) model_mode = sel;
         end
         msu_pkg::KIND_OPERAND: model_operand[idx] = val;
         msu_pkg::KIND_LOAD: begin
            for (int e = 0; e < 16; e++) model_stack[m][lv][e] = model_operand[e];
         end
         msu_pkg::KIND_MULTIPLY: begin
            for (int c = 0; c < 4; c++)
               for (int rw = 0; rw < 4; rw++) begin
                  acc = '0;
                  for (int k = 0; k < 4; k++)
                     acc += model_stack[m][lv][k*4+rw] * model_operand[c*4+k];
                  prod[c*4+rw] = acc;
               end
            for (int e = 0; e < 16; e++) model_stack[m][lv][e] = prod[e];
         end
         msu_pkg::KIND_IDENTITY: begin
            for (int e = 0; e < 16; e++)
               model_stack[m][lv][e] = (e / 4 == e % 4) ? 32'd1 : 32'd0;
         end
         msu_pkg::KIND_PUSH: begin
            if (lv + 1 < DEPTH) begin
               for (int e = 0; e < 16; e++)
                  model_stack[m][lv+1][e] = model_stack[m][lv][e];
               model_level[m] = 5'(lv + 1);
            end else begin
               r.status = msu_pkg::STATUS_PUSH_FULL;
            end
         end
         msu_pkg::KIND_POP: begin
            if (lv > 0) model_level[m] = 5'(lv - 1);
            else r.status = msu_pkg::STATUS_POP_EMPTY;
         end
         default: r.read_value = model_stack[m][lv][idx];
      endcase
      r.stack_level = model_level[model_mode];
      return r;
   endfunction

   // send one word: optional gap, hold until accepted, then predict
   task automatic send_word(msu_pkg::kind_type kind, logic [1:0] sel, logic [3:0] idx,
                            logic [31:0] val);
      reply_type r;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_mode_select   <= sel;
      req_element_index <= idx;
      req_element_value <= val;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      r = apply_command(kind, sel, idx, val);
      if (r.status != msu_pkg::STATUS_OK) refusals++;
      pending_replies.push_back(r);
      words_sent++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   // check each accepted response against the oldest prediction; watchdog
   always @(negedge clock) begin
      reply_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected response read_value %h level %0d status %0d",
                        $time, rsp_read_value, rsp_stack_level, rsp_status);
               failures++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $display("%0t: read_value expected %h actual %h",
                           $time, want.read_value, rsp_read_value);
                  failures++;
               end
               if (rsp_stack_level !== want.stack_level) begin
                  $display("%0t: stack_level expected %0d actual %0d",
                           $time, want.stack_level, rsp_stack_level);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  failures++;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: watchdog expired with %0d responses outstanding",
                     $time, pending_replies.size());
            $display("FAIL matrix_stack_unit");
            $finish;
         end
      end
   end

   // mode select, including the ignored value, and extreme operands
   task automatic test_modes_and_operands();
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd5, '0);
      send_word(msu_pkg::KIND_MODE, 2'd3, 4'd0, '0);
      send_word(msu_pkg::KIND_MODE, msu_pkg::MODE_TEXTURE, 4'd15, 32'hFFFF_FFFF);
      send_word(msu_pkg::KIND_MODE, msu_pkg::MODE_PROJECTION, 4'd0, '0);
      send_word(msu_pkg::KIND_OPERAND, 2'd3, 4'd0, 32'h8000_0000);
      send_word(msu_pkg::KIND_OPERAND, 2'd0, 4'd15, 32'h7FFF_FFFF);
      send_word(msu_pkg::KIND_OPERAND, 2'd0, 4'd5, 32'hFFFF_FFFF);
      send_word(msu_pkg::KIND_OPERAND, 2'd0, 4'd10, 32'd3);
      send_word(msu_pkg::KIND_LOAD, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd15, '0);
      send_word(msu_pkg::KIND_MULTIPLY, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd10, '0);
      send_word(msu_pkg::KIND_IDENTITY, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd5, '0);
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd4, '0);
      drop_valid();
      wait_drained();
   endtask

   // fill one stack past the top, then pop past the bottom; check stale levels
   task automatic test_stack_limits();
      send_word(msu_pkg::KIND_MODE, msu_pkg::MODE_MODELVIEW, 4'd0, '0);
      send_word(msu_pkg::KIND_POP, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_OPERAND, 2'd0, 4'd3, 32'h1234_5678);
      send_word(msu_pkg::KIND_LOAD, 2'd0, 4'd0, '0);
      for (int i = 0; i < DEPTH; i++) send_word(msu_pkg::KIND_PUSH, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_IDENTITY, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_POP, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd3, '0);
      for (int i = 0; i < DEPTH; i++) send_word(msu_pkg::KIND_POP, 2'd0, 4'd0, '0);
      send_word(msu_pkg::KIND_READ, 2'd0, 4'd3, '0);
      drop_valid();
      wait_drained();
   endtask

   // random command mix; pushes (12%) and pops (11%) nearly balanced so levels wander
   task automatic test_random_phase(int count, int gap, int stall);
      int          pick;
      logic [31:0] val;
      logic [1:0]  sel;
      logic [3:0]  idx;
      logic [31:0] junk;
      idle_pct = gap;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         sel  = 2'($urandom);
         idx  = 4'($urandom);
         junk = $urandom;
         case ($urandom_range(3))
            0: val = $urandom_range(7) - 3;
            1: val = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: val = $urandom;
         endcase
         if (pick < 8)
            send_word(msu_pkg::KIND_MODE, sel, idx, junk);
         else if (pick < 38)
            send_word(msu_pkg::KIND_OPERAND, sel, idx, val);
         else if (pick < 44)
            send_word(msu_pkg::KIND_LOAD, sel, idx, junk);
         else if (pick < 52)
            send_word(msu_pkg::KIND_MULTIPLY, sel, idx, junk);
         else if (pick < 56)
            send_word(msu_pkg::KIND_IDENTITY, sel, idx, junk);
         else if (pick < 68)
            send_word(msu_pkg::KIND_PUSH, sel, idx, junk);
         else if (pick < 79)
            send_word(msu_pkg::KIND_POP, sel, idx, junk);
         else
            send_word(msu_pkg::KIND_READ, sel, idx, junk);
      end
      drop_valid();
      wait_drained();
   endtask

   initial begin
      model_clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_modes_and_operands();
      test_stack_limits();
      test_random_phase(300, 0, 0);
      test_random_phase(300, 49, 0);
      test_random_phase(300, 0, 49);
      test_random_phase(300, 36, 36);
      $display("Sent %0d command words, checked %0d responses, %0d refused push/pop.",
               words_sent, words_checked, refusals);
      $display("Covered all commands, three stacks, full and empty limits, four pacing phases.");
      if (failures == 0 && pending_replies.size() == 0) begin
         $display("PASS matrix_stack_unit");
      end else begin
         $display("FAIL matrix_stack_unit");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/msu_pkg.sv
rtl/msu_datapath.sv
rtl/msu_controller.sv
rtl/matrix_stack_unit.sv
tb/sv/matrix_stack_unit_test.sv
